@@ hw/rtl/pkc_pkg.sv @@
// ----------------------------------------------------------------------------
// Pressed-key code table package
// Shared constants, field positions and the per-cell control struct.
// ----------------------------------------------------------------------------
package pkc_pkg;

   // default number of entry cells
   localparam int TableDepthDefault = 32;

   // field widths
   localparam int ScanW = 9;
   localparam int CharW = 16;

   // request opcodes (carried on req_tuser)
   typedef enum logic {
      OP_PRESS   = 1'b0,
      OP_RELEASE = 1'b1
   } pkc_op_type;

   // request tdata layout: scan_code, char_code, zero pad
   localparam int ReqDataW  = 32;
   localparam int ReqScanLo = 0;
   localparam int ReqCharLo = ReqScanLo + ScanW;

   // response tdata layout: found, released_char, evicted, zero pad
   localparam int RspDataW    = 24;
   localparam int RspFoundBit = 0;
   localparam int RspCharLo   = 1;
   localparam int RspEvictBit = RspCharLo + CharW;
   localparam int RspUsedW    = RspEvictBit + 1;

   // control for one entry cell in one cycle
   typedef struct packed {
      logic valid;       // cell lies below the fill count
      logic shift;       // take the contents of the next cell
      logic load_new;    // take the incoming scan and char code
      logic write_char;  // overwrite the stored char code only
   } pkc_cell_ctrl_type;

endpackage

@@ hw/rtl/pkc_cell.sv @@
// ----------------------------------------------------------------------------
// Pressed-key table entry cell
// Holds one scan/char pair, compares its scan code with the request key and
// loads from its neighbor when the row shifts toward the front.
// ----------------------------------------------------------------------------
module pkc_cell (
   input  logic                          clock,
   input  pkc_pkg::pkc_cell_ctrl_type    ctrl,
   input  logic [pkc_pkg::ScanW-1:0]     key,
   input  logic [pkc_pkg::CharW-1:0]     chr,
   input  logic [pkc_pkg::ScanW-1:0]     next_scan,
   input  logic [pkc_pkg::CharW-1:0]     next_char,
   output logic [pkc_pkg::ScanW-1:0]     scan,
   output logic [pkc_pkg::CharW-1:0]     char_out,
   output logic                          match
);

   logic [pkc_pkg::ScanW-1:0] scan_ff, scan_in;
   logic [pkc_pkg::CharW-1:0] char_ff, char_in;

   // next contents: new entry beats shift beats char update
   always_comb begin
      scan_in = scan_ff;
      char_in = char_ff;
      if (ctrl.load_new) begin
         scan_in = key;
         char_in = chr;
      end else if (ctrl.shift) begin
         scan_in = next_scan;
         char_in = next_char;
      end else if (ctrl.write_char) begin
         char_in = chr;
      end
   end

   // entry storage, no reset: only cells below the count are ever used
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      char_ff <= char_in;
   end

   assign scan     = scan_ff;
   assign char_out = char_ff;
   assign match    = ctrl.valid && (scan_ff == key);

endmodule

@@ hw/rtl/pressed_key_code_table.sv @@
// ----------------------------------------------------------------------------
// Pressed-key code table
// Ordered table of held keys in a row of entry cells, oldest at cell 0.
//
//   channel | dir | tdata                          | tuser
//   req_    | in  | scan_code[8:0], char_code[24:9]| opcode (0 press, 1 release)
//   rsp_    | out | found[0], released_char[16:1], | -
//           |     | evicted[17]                    |
//
// Every cell compares its scan code with the key and the row shifts or
// loads in the same cycle the request is accepted.
// The result is registered and shows on rsp_ the following cycle.
// A new request is taken while the response register is empty or drained.
// Reset clears the fill count and the response valid; cell contents are kept.
// ----------------------------------------------------------------------------
module pressed_key_code_table #(
   parameter int TABLE_DEPTH = pkc_pkg::TableDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pkc_pkg::ReqDataW-1:0]  req_tdata,  // scan_code, char_code, pad
   input  logic                          req_tuser,  // opcode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pkc_pkg::RspDataW-1:0]  rsp_tdata   // found, released_char, evicted, pad
);

   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam int CntW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CntW-1:0] CntFull = CntW'(TABLE_DEPTH);

   logic [CntW-1:0] count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [pkc_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;

   logic accept;
   logic is_release;
   logic [pkc_pkg::ScanW-1:0] key;
   logic [pkc_pkg::CharW-1:0] chr;

   logic [TABLE_DEPTH-1:0] match;
   logic [pkc_pkg::ScanW-1:0] cell_scan [TABLE_DEPTH];
   logic [pkc_pkg::CharW-1:0] cell_char [TABLE_DEPTH];
   pkc_pkg::pkc_cell_ctrl_type cell_ctrl [TABLE_DEPTH];

   logic            hit;
   logic            full;
   logic [IdxW-1:0] hit_idx;
   logic [pkc_pkg::CharW-1:0] hit_char;
   logic            press_hit, press_miss, release_hit, evict;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_release = (pkc_pkg::pkc_op_type'(req_tuser) == pkc_pkg::OP_RELEASE);
   assign key        = req_tdata[pkc_pkg::ReqScanLo +: pkc_pkg::ScanW];
   assign chr        = req_tdata[pkc_pkg::ReqCharLo +: pkc_pkg::CharW];

   // scan codes in the table are unique, so at most one cell matches
   always_comb begin
      hit_idx  = '0;
      hit_char = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_idx  = hit_idx | (IdxW'(i) & {IdxW{match[i]}});
         hit_char = hit_char | (cell_char[i] & {pkc_pkg::CharW{match[i]}});
      end
   end

   assign hit         = |match;
   assign full        = (count_ff == CntFull);
   assign press_hit   = accept && !is_release && hit;
   assign press_miss  = accept && !is_release && !hit;
   assign release_hit = accept && is_release && hit;
   assign evict       = press_miss && full;

   // per-cell control and the row of cells
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      localparam logic [IdxW-1:0] Idx = IdxW'(g);

      always_comb begin
         cell_ctrl[g].valid      = (CntW'(g) < count_ff);
         cell_ctrl[g].shift      = evict || (release_hit && (Idx >= hit_idx));
         cell_ctrl[g].load_new   = press_miss &&
                                   (full ? (g == TABLE_DEPTH - 1)
                                         : (CntW'(g) == count_ff));
         cell_ctrl[g].write_char = press_hit && (Idx == hit_idx);
      end

      if (g == TABLE_DEPTH - 1) begin : g_last
         pkc_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[g]),
            .key       (key),
            .chr       (chr),
            .next_scan (key),
            .next_char (chr),
            .scan      (cell_scan[g]),
            .char_out  (cell_char[g]),
            .match     (match[g])
         );
      end else begin : g_mid
         pkc_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[g]),
            .key       (key),
            .chr       (chr),
            .next_scan (cell_scan[g+1]),
            .next_char (cell_char[g+1]),
            .scan      (cell_scan[g]),
            .char_out  (cell_char[g]),
            .match     (match[g])
         );
      end
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      if (press_miss && !full) begin
         count_in = count_ff + CntW'(1);
      end else if (release_hit) begin
         count_in = count_ff - CntW'(1);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[pkc_pkg::RspFoundBit] = hit;
         rsp_data_in[pkc_pkg::RspCharLo +: pkc_pkg::CharW] =
            is_release ? hit_char : '0;
         rsp_data_in[pkc_pkg::RspEvictBit] = evict;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/pkc_checker.sv @@
// ----------------------------------------------------------------------------
// Pressed-key code table port checker
// Watches the top-level ports and flags inconsistent responses.
// ----------------------------------------------------------------------------
module pkc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [pkc_pkg::RspDataW-1:0]  rsp_tdata
);

   logic found, evicted;
   logic [pkc_pkg::CharW-1:0] rel_char;

   assign found    = rsp_tdata[pkc_pkg::RspFoundBit];
   assign evicted  = rsp_tdata[pkc_pkg::RspEvictBit];
   assign rel_char = rsp_tdata[pkc_pkg::RspCharLo +: pkc_pkg::CharW];

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // every accepted request yields a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no response");

   // a hit and an eviction never come together
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(found && evicted))
      else $error("found and evicted both set");

   // a returned char code implies a hit
   a_char_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rel_char != '0) |-> found)
      else $error("released char without hit");

   // pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[pkc_pkg::RspDataW-1:pkc_pkg::RspUsedW] == '0))
      else $error("response pad bits not zero");

endmodule

bind pressed_key_code_table pkc_checker u_pkc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/tb_pressed_key_code_table.sv @@
// ----------------------------------------------------------------------------
// Testbench for the pressed-key code table
// Drives press and release transactions into req_, predicts each response
// from a private copy of the held-key table and checks every rsp_
// transaction field by field. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_pressed_key_code_table;

   localparam int Depth      = pkc_pkg::TableDepthDefault;
   localparam int CycleLimit = 400000;
   localparam int ScanW      = pkc_pkg::ScanW;
   localparam int CharW      = pkc_pkg::CharW;
   localparam int ReqDataW   = pkc_pkg::ReqDataW;
   localparam int RspDataW   = pkc_pkg::RspDataW;
   localparam int RspUsedW   = pkc_pkg::RspUsedW;

   // expected response of one key event
   typedef struct packed {
      logic             found;
      logic [CharW-1:0] released_char;
      logic             evicted;
   } key_result_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;  // scan_code, char_code, pad
   logic                req_tuser  = 1'b0; // opcode
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;        // found, released_char, evicted, pad

   // predicted table contents, oldest entry at index 0
   logic [ScanW-1:0] held_scan [Depth];
   logic [CharW-1:0] held_char [Depth];
   int               held_count = 0;

   key_result_type pending_results[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          stall_left  = 0;
   bit          req_gap_on  = 1'b0;
   bit          rsp_stall_on = 1'b0;

   pressed_key_code_table #(
      .TABLE_DEPTH(Depth)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_pressed_key_code_table: FAIL");
         $finish;
      end
   end

   // receiver back-pressure in bursts
   always @(negedge clock) begin
      if (rsp_stall_on && stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // drop entry pos and move the younger ones one place forward
   function automatic void remove_entry(int pos);
      int k;
      for (k = pos; k + 1 < held_count; k++) begin
         held_scan[k] = held_scan[k + 1];
         held_char[k] = held_char[k + 1];
      end
      held_count--;
   endfunction

   // update the predicted table and return the response it must give
   function automatic key_result_type apply_key_event(pkc_pkg::pkc_op_type op,
                                                      logic [ScanW-1:0] scan,
                                                      logic [CharW-1:0] chr);
      key_result_type r;
      int          hit;
      int          i;
      r   = '0;
      hit = -1;
      for (i = 0; i < held_count; i++) begin
         if (hit < 0 && held_scan[i] == scan) hit = i;
      end
      if (op == pkc_pkg::OP_PRESS) begin
         if (hit >= 0) begin
            held_char[hit] = chr;
            r.found = 1'b1;
         end else begin
            // full table: oldest key goes first
            if (held_count == Depth) begin
               remove_entry(0);
               r.evicted = 1'b1;
            end
            held_scan[held_count] = scan;
            held_char[held_count] = chr;
            held_count++;
         end
      end else if (hit >= 0) begin
         r.found         = 1'b1;
         r.released_char = held_char[hit];
         remove_entry(hit);
      end
      return r;
   endfunction

   // one request transaction; entered and left at a falling edge, tvalid left high
   task automatic send_key_event(pkc_pkg::pkc_op_type op, logic [ScanW-1:0] scan,
                                 logic [CharW-1:0] chr);
      logic [ReqDataW-1:0] d;
      if (req_gap_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      d = '0;
      d[pkc_pkg::ReqScanLo +: ScanW] = scan;
      d[pkc_pkg::ReqCharLo +: CharW] = chr;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(apply_key_event(op, scan, chr));
      @(negedge clock);
   endtask

   // random presses and releases over a window of pool_size scan codes
   task automatic run_mixed_traffic(int n, int pool_size, int release_pct);
      int                  base;
      logic [ScanW-1:0]    scan;
      pkc_pkg::pkc_op_type op;
      base = $urandom_range(0, 511);
      repeat (n) begin
         if ($urandom_range(0, 99) < release_pct) begin
            op = pkc_pkg::OP_RELEASE;
            // mostly release a key that is held, at any position
            if (held_count > 0 && $urandom_range(0, 3) != 0)
               scan = held_scan[$urandom_range(0, held_count - 1)];
            else
               scan = ScanW'(base + $urandom_range(0, pool_size - 1));
         end else begin
            op   = pkc_pkg::OP_PRESS;
            scan = ScanW'(base + $urandom_range(0, pool_size - 1));
         end
         send_key_event(op, scan, CharW'($urandom));
      end
   endtask

   // field extremes, press hit, release hit and miss, removal from each end
   task automatic test_directed_cases();
      req_gap_on   = 1'b0;
      rsp_stall_on = 1'b0;
      send_key_event(pkc_pkg::OP_RELEASE, 9'h000, 16'hffff);  // empty table
      send_key_event(pkc_pkg::OP_PRESS,   9'h000, 16'h0000);
      send_key_event(pkc_pkg::OP_PRESS,   9'h1ff, 16'hffff);
      send_key_event(pkc_pkg::OP_PRESS,   9'h000, 16'ha5a5);  // overwrite in place
      send_key_event(pkc_pkg::OP_RELEASE, 9'h1ff, 16'h1234);
      send_key_event(pkc_pkg::OP_RELEASE, 9'h1ff, 16'h0000);  // already gone
      send_key_event(pkc_pkg::OP_PRESS,   9'h155, 16'h5555);
      send_key_event(pkc_pkg::OP_PRESS,   9'h0aa, 16'haaaa);
      send_key_event(pkc_pkg::OP_RELEASE, 9'h155, 16'h0000);  // middle entry
      send_key_event(pkc_pkg::OP_RELEASE, 9'h000, 16'h0000);  // oldest entry
      send_key_event(pkc_pkg::OP_RELEASE, 9'h0aa, 16'hffff);
      send_key_event(pkc_pkg::OP_RELEASE, 9'h0aa, 16'h0000);
      send_key_event(pkc_pkg::OP_PRESS,   9'h100, 16'h8000);
      send_key_event(pkc_pkg::OP_PRESS,   9'h001, 16'h0001);
      send_key_event(pkc_pkg::OP_RELEASE, 9'h001, 16'h0000);  // youngest entry
      send_key_event(pkc_pkg::OP_RELEASE, 9'h100, 16'h0000);
   endtask

   // overfill the table, then hit it while full and release across it
   task automatic test_fill_and_evict();
      int base;
      int i;
      req_gap_on   = 1'b1;
      rsp_stall_on = 1'b1;
      base = $urandom_range(0, 511);
      for (i = 0; i < Depth + 8; i++)
         send_key_event(pkc_pkg::OP_PRESS, ScanW'(base + i), CharW'($urandom));
      send_key_event(pkc_pkg::OP_PRESS,   ScanW'(base + 20), CharW'($urandom));
      send_key_event(pkc_pkg::OP_RELEASE, ScanW'(base), 16'h0000);
      send_key_event(pkc_pkg::OP_RELEASE, ScanW'(base + 8), 16'h0000);
      for (i = 0; i < 4; i++)
         send_key_event(pkc_pkg::OP_RELEASE,
                        ScanW'(base + $urandom_range(9, Depth + 7)), 16'h0000);
      for (i = 0; i < 6; i++)
         send_key_event(pkc_pkg::OP_PRESS, ScanW'(base + 100 + i), CharW'($urandom));
   endtask

   // several traffic shapes: hit-heavy, fill-heavy, sparse keys
   task automatic test_mixed_churn();
      req_gap_on = 1'b1;  rsp_stall_on = 1'b0;
      run_mixed_traffic(220, 8, 40);
      req_gap_on = 1'b0;  rsp_stall_on = 1'b1;
      run_mixed_traffic(220, 24, 30);
      req_gap_on = 1'b1;  rsp_stall_on = 1'b1;
      run_mixed_traffic(220, 48, 20);
      run_mixed_traffic(200, 512, 35);
      req_gap_on = 1'b0;  rsp_stall_on = 1'b0;
      run_mixed_traffic(150, 36, 45);
   endtask

   // sender holds off until every response is back
   task automatic test_pause_until_drained();
      req_gap_on   = 1'b1;
      rsp_stall_on = 1'b1;
      repeat (2) begin
         run_mixed_traffic(40, 40, 30);
         req_tvalid <= 1'b0;
         do @(negedge clock); while (pending_results.size() != 0);
      end
   endtask

   // closing stretch with both sides at full rate
   task automatic test_back_to_back();
      req_gap_on   = 1'b0;
      rsp_stall_on = 1'b0;
      run_mixed_traffic(200, 40, 35);
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      key_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response transaction, rsp_tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[pkc_pkg::RspFoundBit] !== want.found) begin
               $error("found: expected %b, got %b", want.found,
                      rsp_tdata[pkc_pkg::RspFoundBit]);
               error_count++;
            end
            if (rsp_tdata[pkc_pkg::RspCharLo +: CharW] !== want.released_char) begin
               $error("released_char: expected %h, got %h", want.released_char,
                      rsp_tdata[pkc_pkg::RspCharLo +: CharW]);
               error_count++;
            end
            if (rsp_tdata[pkc_pkg::RspEvictBit] !== want.evicted) begin
               $error("evicted: expected %b, got %b", want.evicted,
                      rsp_tdata[pkc_pkg::RspEvictBit]);
               error_count++;
            end
            if (rsp_tdata[RspDataW-1:RspUsedW] !== '0) begin
               $error("pad: expected %h, got %h", {(RspDataW - RspUsedW){1'b0}},
                      rsp_tdata[RspDataW-1:RspUsedW]);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_fill_and_evict();
      test_mixed_churn();
      test_pause_until_drained();
      test_back_to_back();

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_pressed_key_code_table: PASS");
      end else begin
         $display("tb_pressed_key_code_table: FAIL");
      end
      $finish;
   end

endmodule

@@ pressed_key_code_table.f @@
hw/rtl/pkc_pkg.sv
hw/rtl/pkc_cell.sv
hw/rtl/pressed_key_code_table.sv
hw/rtl/pkc_checker.sv
tb/tb_pressed_key_code_table.sv
